/* rtl/sbx_pkg.sv */
// Shared types, constants and face tables for the segment/box intersection pipeline.
package sbx_pkg;

    localparam int COORD_W      = 32;
    localparam int MAG_W        = 32;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int QUOT_W       = MAG_W;
    localparam int NUM_FACES    = 6;
    localparam int FRONT_STAGES = 2;
    localparam int PICK_STAGES  = 8;
    localparam int LATENCY      = FRONT_STAGES + QUOT_W + PICK_STAGES;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic [PROD_W-1:0]         t_prod;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        t_coord box_min_x;
        t_coord box_min_y;
        t_coord box_min_z;
        t_coord box_max_x;
        t_coord box_max_y;
        t_coord box_max_z;
    } t_seg_req;

    typedef struct packed {
        logic   hit;
        t_coord hit_x;
        t_coord hit_y;
        t_coord hit_z;
    } t_seg_rsp;

    // per-request data carried alongside the dividers
    typedef struct packed {
        logic [2:0][COORD_W-1:0]           s;
        logic [2:0][COORD_W-1:0]           bmin;
        logic [2:0][COORD_W-1:0]           bmax;
        logic [2:0]                        dneg;
        logic [NUM_FACES-1:0][MAG_W-1:0]   nmag;
        logic [NUM_FACES-1:0][MAG_W-1:0]   dmag;
        logic [NUM_FACES-1:0][COORD_W-1:0] plane;
        logic [NUM_FACES-1:0]              tneg;
        logic [NUM_FACES-1:0]              pre_ok;
    } t_meta;

    typedef struct packed {
        t_meta                                 meta;
        logic [NUM_FACES-1:0][1:0][PROD_W-1:0] prod;
    } t_front;

    typedef struct packed {
        logic                    ok;
        t_mag                    n;
        t_mag                    d;
        logic [2:0][COORD_W-1:0] pt;
    } t_cand;

    // faces: top, bottom, front, back, left, right
    function automatic t_axis face_axis(input logic [2:0] f);
        t_axis a;
        case (f) inside
            3'd0, 3'd1: a = AXIS_Y;
            3'd2, 3'd3: a = AXIS_Z;
            default:    a = AXIS_X;
        endcase
        return a;
    endfunction

    function automatic logic face_is_max(input logic [2:0] f);
        return ~f[0];
    endfunction

    // the two in-plane axes of a face on axis a
    function automatic t_axis other_axis(input t_axis a, input logic j);
        t_axis k;
        case (a)
            AXIS_X:  k = j ? AXIS_Z : AXIS_Y;
            AXIS_Y:  k = j ? AXIS_Z : AXIS_X;
            default: k = j ? AXIS_Y : AXIS_X;
        endcase
        return k;
    endfunction

    // a - b as {negative, magnitude}
    function automatic logic [MAG_W:0] sdiff(input logic [COORD_W-1:0] a,
                                             input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] nd;
        d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        nd = ~d + 1'b1;
        return d[COORD_W] ? {1'b1, nd[MAG_W-1:0]} : {1'b0, d[MAG_W-1:0]};
    endfunction

endpackage

/* rtl/segment_box_intersection.sv */
// Top level: segment vs axis-aligned box intersection, fully pipelined.
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------------------
//   request   | start / busy       | i_req  (t_seg_req)
//   result    | o_done strobe      | o_rsp  (t_seg_rsp)
//
// One request per cycle while busy is low; each result passes through
// 2 front stages, 32 divider stages of one quotient bit each and 8 select stages.
// busy is high only while reset is held and for the first cycle after it.
// Reset clears the valid bits of every stage; data in flight is dropped.
// The result side has no back-pressure, so nothing ever stalls.
module segment_box_intersection
    import sbx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_seg_req i_req,
    output logic     o_done,
    output t_seg_rsp o_rsp
);

    logic   r_busy;
    logic   accept;
    logic   front_valid;
    t_front front;
    logic   meta_valid;
    logic [$bits(t_meta)-1:0] meta_bits;
    logic [NUM_FACES-1:0][1:0][MAG_W-1:0] quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    sbx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .o_valid (front_valid),
        .o_front (front)
    );

    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        for (genvar j = 0; j < 2; j++) begin : g_axis
            sbx_div u_div (
                .i_clk      (i_clk),
                .i_dividend (front.prod[f][j]),
                .i_divisor  (front.meta.dmag[f]),
                .o_quotient (quo[f][j])
            );
        end
    end

    sbx_pipe #(
        .W     ($bits(t_meta)),
        .DEPTH (QUOT_W)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front.meta),
        .o_valid (meta_valid),
        .o_data  (meta_bits)
    );

    sbx_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (meta_valid),
        .i_meta  (t_meta'(meta_bits)),
        .i_quo   (quo),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("result missing after request");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without a request");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.hit) |->
            (o_rsp.hit_x == '0) && (o_rsp.hit_y == '0) && (o_rsp.hit_z == '0))
        else $error("miss with nonzero point");

endmodule

/* rtl/sbx_pipe.sv */
// Delay line with valid bits for data that runs beside the dividers.
module sbx_pipe #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_data[i] <= r_data[i-1];
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

/* rtl/sbx_front.sv */
// Front stages: axis differences, face plane distances, range checks and products.
module sbx_front
    import sbx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_seg_req i_req,
    output logic     o_valid,
    output t_front   o_front
);

    logic [2:0][COORD_W-1:0] s, e, mn, mx;
    logic [2:0]              n_dneg;
    logic [2:0][MAG_W-1:0]   n_dmag;
    logic [NUM_FACES-1:0]              n_nneg;
    logic [NUM_FACES-1:0][MAG_W-1:0]   n_nmag;
    logic [NUM_FACES-1:0][COORD_W-1:0] n_plane;

    logic                              r_v1;
    logic [2:0][COORD_W-1:0]           r_s, r_mn, r_mx;
    logic [2:0]                        r_dneg;
    logic [2:0][MAG_W-1:0]             r_dmag;
    logic [NUM_FACES-1:0]              r_nneg;
    logic [NUM_FACES-1:0][MAG_W-1:0]   r_nmag;
    logic [NUM_FACES-1:0][COORD_W-1:0] r_plane;

    t_front n_front, r_front;
    logic   r_v2;

    always_comb begin
        t_axis            a;
        logic [COORD_W-1:0] pl;
        s  = {i_req.start_z, i_req.start_y, i_req.start_x};
        e  = {i_req.end_z, i_req.end_y, i_req.end_x};
        mn = {i_req.box_min_z, i_req.box_min_y, i_req.box_min_x};
        mx = {i_req.box_max_z, i_req.box_max_y, i_req.box_max_x};
        for (int k = 0; k < 3; k++) begin
            {n_dneg[k], n_dmag[k]} = sdiff(e[k], s[k]);
        end
        for (int f = 0; f < NUM_FACES; f++) begin
            a  = face_axis(3'(f));
            pl = face_is_max(3'(f)) ? mx[a] : mn[a];
            n_plane[f] = pl;
            {n_nneg[f], n_nmag[f]} = sdiff(pl, s[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= s;
        r_mn    <= mn;
        r_mx    <= mx;
        r_dneg  <= n_dneg;
        r_dmag  <= n_dmag;
        r_nneg  <= n_nneg;
        r_nmag  <= n_nmag;
        r_plane <= n_plane;
    end

    always_comb begin
        t_axis a;
        t_axis k;
        t_mag  dm;
        logic  tn;
        n_front.meta.s     = r_s;
        n_front.meta.bmin  = r_mn;
        n_front.meta.bmax  = r_mx;
        n_front.meta.dneg  = r_dneg;
        n_front.meta.nmag  = r_nmag;
        n_front.meta.plane = r_plane;
        for (int f = 0; f < NUM_FACES; f++) begin
            a  = face_axis(3'(f));
            dm = r_dmag[a];
            tn = r_nneg[f] ^ r_dneg[a];
            n_front.meta.dmag[f] = dm;
            n_front.meta.tneg[f] = tn;
            // crossing must lie at t in [0,1] on a moving axis
            n_front.meta.pre_ok[f] = (dm != '0) &&
                !(((r_nmag[f] != '0) && tn) || (r_nmag[f] > dm));
            for (int j = 0; j < 2; j++) begin
                k = other_axis(a, 1'(j));
                n_front.prod[f][j] = PROD_W'(r_nmag[f]) * PROD_W'(r_dmag[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_front = r_front;

endmodule

/* rtl/sbx_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating.
module sbx_div
    import sbx_pkg::*;
(
    input  logic  i_clk,
    input  t_prod i_dividend,
    input  t_mag  i_divisor,
    output t_mag  o_quotient
);

    // stage inputs
    t_mag rem_in [QUOT_W];
    t_mag low_in [QUOT_W];
    t_mag quo_in [QUOT_W];
    t_mag div_in [QUOT_W];

    t_mag r_rem [QUOT_W];
    t_mag r_low [QUOT_W];
    t_mag r_quo [QUOT_W];
    t_mag r_div [QUOT_W];

    t_mag n_rem [QUOT_W];
    t_mag n_low [QUOT_W];
    t_mag n_quo [QUOT_W];

    // upper half is below the divisor whenever the quotient fits
    assign rem_in[0] = i_dividend[PROD_W-1:MAG_W];
    assign low_in[0] = i_dividend[MAG_W-1:0];
    assign quo_in[0] = '0;
    assign div_in[0] = i_divisor;

    for (genvar i = 1; i < QUOT_W; i++) begin : g_link
        assign rem_in[i] = r_rem[i-1];
        assign low_in[i] = r_low[i-1];
        assign quo_in[i] = r_quo[i-1];
        assign div_in[i] = r_div[i-1];
    end

    always_comb begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           fits;
        for (int i = 0; i < QUOT_W; i++) begin
            trial    = {rem_in[i], low_in[i][MAG_W-1]};
            diff     = trial - {1'b0, div_in[i]};
            fits     = trial >= {1'b0, div_in[i]};
            n_rem[i] = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            n_low[i] = {low_in[i][MAG_W-2:0], 1'b0};
            n_quo[i] = {quo_in[i][MAG_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUOT_W; i++) begin
            r_rem[i] <= n_rem[i];
            r_low[i] <= n_low[i];
            r_quo[i] <= n_quo[i];
            r_div[i] <= div_in[i];
        end
    end

    assign o_quotient = r_quo[QUOT_W-1];

endmodule

/* rtl/sbx_pick.sv */
// Crossing points, face bounds test and nearest-hit selection tree.
module sbx_pick
    import sbx_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  t_meta                           i_meta,
    input  logic [NUM_FACES-1:0][1:0][MAG_W-1:0] i_quo,
    output logic                            o_done,
    output t_seg_rsp                        o_rsp
);

    logic [NUM_FACES-1:0][2:0][COORD_W-1:0] n_pt, r_pt;
    t_meta r_m1;
    logic  r_v1;

    t_cand n_cand [NUM_FACES];
    t_cand r_cand [NUM_FACES];
    logic  r_v2;

    t_cand r_a_l [3];
    t_cand r_a_r [3];
    t_prod r_a_pl [3];
    t_prod r_a_pr [3];
    logic  r_va;

    t_cand r_w [3];
    logic  r_vw;

    t_cand r_b_l, r_b_r, r_b_c;
    t_prod r_b_pl, r_b_pr;
    logic  r_vb1;

    t_cand r_wb, r_wb_c;
    logic  r_vb2;

    t_cand r_c_l, r_c_r;
    t_prod r_c_pl, r_c_pr;
    logic  r_vc1;

    t_seg_rsp n_rsp, r_rsp;
    t_cand    fin;
    logic     r_done;

    // a valid later candidate wins when the earlier one is invalid or when it is strictly nearer
    function automatic t_cand nearer(input t_cand l, input t_cand r,
                                     input t_prod pl, input t_prod pr);
        return (r.ok && (!l.ok || (pr < pl))) ? r : l;
    endfunction

    always_comb begin
        t_axis a;
        t_axis k;
        for (int f = 0; f < NUM_FACES; f++) begin
            a = face_axis(3'(f));
            n_pt[f][a] = i_meta.plane[f];
            for (int j = 0; j < 2; j++) begin
                k = other_axis(a, 1'(j));
                n_pt[f][k] = (i_meta.dneg[k] ^ i_meta.tneg[f]) ?
                             i_meta.s[k] - i_quo[f][j] : i_meta.s[k] + i_quo[f][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
        r_m1 <= i_meta;
    end

    always_comb begin
        t_axis a;
        t_axis k;
        for (int f = 0; f < NUM_FACES; f++) begin
            a = face_axis(3'(f));
            n_cand[f].ok = r_m1.pre_ok[f];
            n_cand[f].n  = r_m1.nmag[f];
            n_cand[f].d  = r_m1.dmag[f];
            n_cand[f].pt = r_pt[f];
            for (int j = 0; j < 2; j++) begin
                k = other_axis(a, 1'(j));
                if (($signed(r_pt[f][k]) < $signed(r_m1.bmin[k])) ||
                    ($signed(r_pt[f][k]) > $signed(r_m1.bmax[k]))) begin
                    n_cand[f].ok = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    // pairs: top/bottom, front/back, left/right
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_l[i]  <= r_cand[2*i];
            r_a_r[i]  <= r_cand[2*i+1];
            r_a_pl[i] <= PROD_W'(r_cand[2*i].n) * PROD_W'(r_cand[2*i+1].d);
            r_a_pr[i] <= PROD_W'(r_cand[2*i+1].n) * PROD_W'(r_cand[2*i].d);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_w[i] <= nearer(r_a_l[i], r_a_r[i], r_a_pl[i], r_a_pr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_l  <= r_w[0];
        r_b_r  <= r_w[1];
        r_b_c  <= r_w[2];
        r_b_pl <= PROD_W'(r_w[0].n) * PROD_W'(r_w[1].d);
        r_b_pr <= PROD_W'(r_w[1].n) * PROD_W'(r_w[0].d);
    end

    always_ff @(posedge i_clk) begin
        r_wb   <= nearer(r_b_l, r_b_r, r_b_pl, r_b_pr);
        r_wb_c <= r_b_c;
    end

    always_ff @(posedge i_clk) begin
        r_c_l  <= r_wb;
        r_c_r  <= r_wb_c;
        r_c_pl <= PROD_W'(r_wb.n) * PROD_W'(r_wb_c.d);
        r_c_pr <= PROD_W'(r_wb_c.n) * PROD_W'(r_wb.d);
    end

    always_comb begin
        fin         = nearer(r_c_l, r_c_r, r_c_pl, r_c_pr);
        n_rsp.hit   = fin.ok;
        n_rsp.hit_x = fin.ok ? t_coord'(fin.pt[0]) : '0;
        n_rsp.hit_y = fin.ok ? t_coord'(fin.pt[1]) : '0;
        n_rsp.hit_z = fin.ok ? t_coord'(fin.pt[2]) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_va   <= 1'b0;
            r_vw   <= 1'b0;
            r_vb1  <= 1'b0;
            r_vb2  <= 1'b0;
            r_vc1  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_va   <= r_v2;
            r_vw   <= r_va;
            r_vb1  <= r_vw;
            r_vb2  <= r_vb1;
            r_vc1  <= r_vb2;
            r_done <= r_vc1;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
